// ===== sv/hdt_pkg.sv =====
`timescale 1ns / 1ps

package hdt_pkg;

  // Field widths
  localparam int CoordW    = 16;
  localparam int AngW      = 16;
  localparam int RateW     = 16;
  localparam int TsW       = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = RateW + TsW;
  localparam int MulCntW   = $clog2(TsW + 1);

  // CORDIC datapath: 28-bit vector, 4-bit digits
  localparam int PreShift  = 8;
  localparam int VecW      = 28;
  localparam int DigW      = 4;
  localparam int NumDig    = VecW / DigW;
  localparam int VecIdxW   = $clog2(VecW);
  localparam int AccW      = 32;
  localparam int MaxIters  = 24;
  localparam int TabIdxW   = $clog2(MaxIters);
  localparam int CORDIC_ITERS_DEF = 16;

  localparam logic [AccW-1:0] AngQuarterPos = 32'h4000_0000;
  localparam logic [AccW-1:0] AngQuarterNeg = 32'hC000_0000;
  localparam logic [RateW-2:0] StepMax      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            done;
    logic [AngW-1:0] bearing;
  } cor_res_t;

  // atan(2^-i) in 2^32-per-turn units, rounded
  function automatic logic [AccW-1:0] atan_tab(input logic [TabIdxW-1:0] idx);
    logic [AccW-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hdt_cordic.sv =====
`timescale 1ns / 1ps

// Digit-serial vectoring CORDIC. x and y rotate through their registers
// one digit per cycle, LSB first.
module hdt_cordic #(
  parameter int ITERS = hdt_pkg::CORDIC_ITERS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [hdt_pkg::DiffW-1:0]    dx_i,
  input  logic signed [hdt_pkg::DiffW-1:0]    dz_i,
  output hdt_pkg::cor_res_t                   res_o
);
  import hdt_pkg::*;

  localparam int N       = (ITERS > MaxIters) ? MaxIters : ITERS;
  localparam int IterW   = (N > 1) ? $clog2(N) : 1;
  localparam int DigCntW = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam logic [IterW-1:0]   LastIter = IterW'(N - 1);
  localparam logic [DigCntW-1:0] LastDig  = DigCntW'(NumDig - 1);

  logic                 busy_q, done_q;
  logic [IterW-1:0]     iter_q;
  logic [DigCntW-1:0]   dig_q;
  logic [VecW-1:0]      x_q, y_q, x_d, y_d;
  logic [AccW-1:0]      ang_q, ang_step;
  logic                 zero_q;
  logic                 sx_q, sy_q, cx_q, cy_q;
  logic                 sgx, sgy, cx_out, cy_out;
  logic [DigW-1:0]      xdig, ydig;

  logic signed [VecW-1:0] x0, y0;
  logic                   last_dig;

  assign x0 = {{(VecW - DiffW - PreShift){dz_i[DiffW-1]}}, dz_i, {PreShift{1'b0}}};
  assign y0 = {{(VecW - DiffW - PreShift){dx_i[DiffW-1]}}, dx_i, {PreShift{1'b0}}};

  assign last_dig = (dig_q == LastDig);
  assign ang_step = atan_tab(TabIdxW'(iter_q));

  // One digit of both add/subtract chains. Taps past the top of the
  // register read the sign latched at the start of the rotation.
  always_comb begin
    int                 pos;
    logic [VecIdxW-1:0] tap;
    logic               xs, ys, opx, opy, cx, cy;
    sgx = (dig_q == '0) ? x_q[VecW-1] : sx_q;
    sgy = (dig_q == '0) ? y_q[VecW-1] : sy_q;
    cx  = (dig_q == '0) ? sgy  : cx_q;   // x subtracts when y < 0
    cy  = (dig_q == '0) ? ~sgy : cy_q;   // y subtracts when y >= 0
    for (int k = 0; k < DigW; k++) begin
      pos = int'(dig_q) * DigW + k + int'(iter_q);
      tap = VecIdxW'(k) + VecIdxW'(iter_q);
      xs  = (pos >= VecW) ? sgx : x_q[tap];
      ys  = (pos >= VecW) ? sgy : y_q[tap];
      opx = ys ^ sgy;
      opy = xs ^ ~sgy;
      xdig[k] = x_q[k] ^ opx ^ cx;
      ydig[k] = y_q[k] ^ opy ^ cy;
      cx = (x_q[k] & opx) | (x_q[k] & cx) | (opx & cx);
      cy = (y_q[k] & opy) | (y_q[k] & cy) | (opy & cy);
    end
    cx_out = cx;
    cy_out = cy;
  end

  assign x_d = {xdig, x_q[VecW-1:DigW]};
  assign y_d = {ydig, y_q[VecW-1:DigW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      dig_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
        dig_q  <= '0;
      end else if (busy_q) begin
        if (last_dig) begin
          dig_q <= '0;
          if (iter_q == LastIter) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end else begin
          dig_q <= dig_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (dx_i == '0) && (dz_i == '0);
      if (x0[VecW-1]) begin
        if (!y0[VecW-1]) begin
          x_q   <= y0;
          y_q   <= -x0;
          ang_q <= AngQuarterPos;
        end else begin
          x_q   <= -y0;
          y_q   <= x0;
          ang_q <= AngQuarterNeg;
        end
      end else begin
        x_q   <= x0;
        y_q   <= y0;
        ang_q <= '0;
      end
    end else if (busy_q) begin
      x_q  <= x_d;
      y_q  <= y_d;
      sx_q <= sgx;
      sy_q <= sgy;
      cx_q <= cx_out;
      cy_q <= cy_out;
      if (last_dig) begin
        ang_q <= sgy ? (ang_q - ang_step) : (ang_q + ang_step);
      end
    end
  end

  assign res_o.done    = done_q;
  assign res_o.bearing = zero_q ? '0
                       : (ang_q[AccW-1:AccW-AngW] + AngW'(ang_q[AccW-AngW-1]));

endmodule

// ===== sv/heading_tracker_rate_limited.sv =====
`timescale 1ns / 1ps

// Heading tracker with slew-rate limit. Each input item carries a target
// position, the own position, a time step and a mode (tuser). The block
// finds the bearing atan2(dx, dz) from +z toward +x as a 16-bit binary angle
// (32768 = pi, zero vector gives 0) and either snaps its heading to it or
// turns toward it by at most turn_rate * time_step / 65536 (capped at 32767).
// One item is in work at a time. The bearing comes from the digit-serial
// CORDIC, which rotates its 28-bit vector 4 bits per cycle. The 16x16 step
// multiply runs bit-serially in the shadow of the CORDIC. The result sits in
// an output register, so a new item is taken as soon as the previous result
// is registered, even if the sink has not taken it yet. turn_rate is written
// through the cfg port (always ready); the user must write it only while the
// block is idle, as the block itself does not enforce this.
module heading_tracker_rate_limited #(
  parameter int CORDIC_ITERS = hdt_pkg::CORDIC_ITERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: turn_rate
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // target_x, target_z, own_x, own_z, time_step
  input  logic [0:0]  s_axis_tuser,   // op (1 = snap)
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // heading
);
  import hdt_pkg::*;

  state_e               state_q, state_d;
  logic [RateW-1:0]     rate_q;
  logic [AngW-1:0]      head_q, head_new;
  logic                 op_q;
  logic [TsW-1:0]       ts_q;
  logic [ProdW-1:0]     prod_q;
  logic [MulCntW-1:0]   mcnt_q;
  logic [AngW-1:0]      bear_q;
  logic                 out_valid_q;
  logic [AngW-1:0]      out_data_q;
  logic                 accept, finish, out_free;
  cor_res_t             cor_res;

  logic signed [DiffW-1:0] dx, dz;
  logic [RateW:0]          mul_sum;
  logic [RateW-2:0]        step;
  logic signed [DiffW-1:0] diff, step_s;

  assign cfg_ready_o = 1'b1;

  // dx = target_x - own_x, dz = target_z - own_z, 17 bits each
  assign dx = DiffW'(signed'(s_axis_tdata[15:0]))  - DiffW'(signed'(s_axis_tdata[47:32]));
  assign dz = DiffW'(signed'(s_axis_tdata[31:16])) - DiffW'(signed'(s_axis_tdata[63:48]));

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  hdt_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .dx_i    (dx),
    .dz_i    (dz),
    .res_o   (cor_res)
  );

  // Control FSM
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cor_res.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free && (mcnt_q == '0)) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shift-add multiply, one multiplier bit per cycle
  assign mul_sum = {1'b0, prod_q[ProdW-1:TsW]} + (ts_q[0] ? {1'b0, rate_q} : '0);

  // Step cap, wrapped difference and clamp
  assign step   = prod_q[ProdW-1] ? StepMax : prod_q[ProdW-2:TsW];
  assign step_s = DiffW'({2'b00, step});
  always_comb begin
    diff = DiffW'(signed'(bear_q - head_q));
    if (diff > step_s) begin
      diff = step_s;
    end else if (diff < -step_s) begin
      diff = -step_s;
    end
    head_new = op_q ? bear_q : (head_q + diff[AngW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= '0;
      head_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rate_q <= cfg_data_i;
      end
      if (accept) begin
        mcnt_q <= MulCntW'(TsW);
      end else if (mcnt_q != '0) begin
        mcnt_q <= mcnt_q - 1'b1;
      end
      if (finish) begin
        head_q      <= head_new;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser[0];
      ts_q   <= s_axis_tdata[79:64];
      prod_q <= '0;
    end else if (mcnt_q != '0) begin
      prod_q <= {mul_sum, prod_q[TsW-1:1]};
      ts_q   <= {1'b0, ts_q[TsW-1:1]};
    end
    if (cor_res.done) begin
      bear_q <= cor_res.bearing;
    end
    if (finish) begin
      out_data_q <= head_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/hdt_checker.sv =====
`timescale 1ns / 1ps

module hdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // a new result frees the input side
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not ready after result");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without an item in work");

endmodule

bind heading_tracker_rate_limited hdt_checker u_hdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/heading_tracker_rate_limited_tb.sv =====
`timescale 1ns / 1ps

// One input item as the bench sees it, before packing onto tdata / tuser.
typedef struct packed {
  logic               op;
  logic signed [15:0] tx;
  logic signed [15:0] tz;
  logic signed [15:0] ox;
  logic signed [15:0] oz;
  logic [15:0]        ts;
} track_item_t;

// Tracks heading and turn rate, predicts each result item, checks the outputs.
class heading_scoreboard;
  int unsigned iters;
  logic [15:0] turn_rate;
  logic [15:0] cur_heading;
  logic [15:0] heading_due[$];
  int unsigned faults;
  logic [31:0] atan_steps[24];

  function new(int unsigned n);
    iters = (n > 24) ? 24 : n;
    turn_rate = '0;
    cur_heading = '0;
    faults = 0;
    atan_steps = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                   32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                   32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                   32'd166886, 32'd83443, 32'd41722, 32'd20861,
                   32'd10430, 32'd5215, 32'd2608, 32'd1304,
                   32'd652, 32'd326, 32'd163, 32'd81};
  endfunction

  // Vectoring CORDIC on (dz, dx), angle in 2^32 per turn, rounded to 16 bits.
  function logic [15:0] bearing_of(int dx, int dz);
    longint x, y, t, xs, ys;
    logic [31:0] ang;
    if (dx == 0 && dz == 0) return '0;
    x = longint'(dz) * 256;
    y = longint'(dx) * 256;
    ang = '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = 32'h4000_0000;
      end else begin
        x = -y;
        y = t;
        ang = 32'hC000_0000;
      end
    end
    for (int i = 0; i < iters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - atan_steps[i];
      end
    end
    ang = ang + 32'h0000_8000;
    return ang[31:16];
  endfunction

  function void note_accepted(track_item_t it);
    int dx, dz;
    logic [15:0] aim, gap;
    logic [31:0] prod;
    logic signed [31:0] step, diff;
    dx = $signed(it.tx) - $signed(it.ox);
    dz = $signed(it.tz) - $signed(it.oz);
    aim = bearing_of(dx, dz);
    if (it.op) begin
      cur_heading = aim;
    end else begin
      prod = {16'b0, turn_rate} * {16'b0, it.ts};
      step = {16'b0, prod[31:16]};
      if (step > 32767) step = 32767;
      gap = aim - cur_heading;
      diff = $signed(gap);
      if (diff > step) diff = step;
      else if (diff < -step) diff = -step;
      cur_heading = cur_heading + diff[15:0];
    end
    heading_due.push_back(cur_heading);
  endfunction

  function void check_heading(logic [15:0] got);
    logic [15:0] want;
    if (heading_due.size() == 0) begin
      $display("%0t unexpected result item: heading %0d", $time, $signed(got));
      faults++;
      return;
    end
    want = heading_due.pop_front();
    if (got !== want) begin
      $display("%0t heading mismatch: expected %0d, got %0d",
               $time, $signed(want), $signed(got));
      faults++;
    end
  endfunction

  function int pending();
    return heading_due.size();
  endfunction
endclass

module heading_tracker_rate_limited_tb;

  localparam int CordicIters   = hdt_pkg::CORDIC_ITERS_DEF;
  localparam int ResultLatency = CordicIters * 7 + 2;
  localparam int RandPhases    = 6;
  localparam int PhaseItems    = 190;

  localparam logic OP_TURN = 1'b0;
  localparam logic OP_SNAP = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // target_x, target_z, own_x, own_z, time_step
  logic [0:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // heading

  heading_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // tracking run state for the random part
  int track_left = 0;
  int track_tx, track_tz, track_ox, track_oz;

  always #4 clk_i = ~clk_i;

  heading_tracker_rate_limited #(
    .CORDIC_ITERS(CordicIters)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // result side: check accepted items, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_heading(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int srand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic track_item_t mk_item(logic op, int tx, int tz, int ox, int oz,
                                          int ts);
    track_item_t it;
    it.op = op;
    it.tx = tx[15:0];
    it.tz = tz[15:0];
    it.ox = ox[15:0];
    it.oz = oz[15:0];
    it.ts = ts[15:0];
    return it;
  endfunction

  // 40% tracking runs (fixed target, jittering own position, mostly turns)
  // so the heading converges and both clamped and unclamped turns show up.
  function automatic track_item_t next_random_item();
    int pick, ox, oz, dx, dz;
    logic op;
    pick = $urandom_range(99);
    op = ($urandom_range(99) < 20) ? OP_SNAP : OP_TURN;
    if (pick < 40) begin
      if (track_left == 0) begin
        track_left = srand(4, 20);
        track_tx = srand(-30000, 30000);
        track_tz = srand(-30000, 30000);
        track_ox = srand(-30000, 30000);
        track_oz = srand(-30000, 30000);
      end
      track_left--;
      op = ($urandom_range(99) < 8) ? OP_SNAP : OP_TURN;
      return mk_item(op, track_tx, track_tz, track_ox + srand(-64, 64),
                     track_oz + srand(-64, 64),
                     ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4096));
    end
    if (pick < 60) begin
      return mk_item(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
    end
    ox = srand(-30000, 30000);
    oz = srand(-30000, 30000);
    if (pick < 74) begin
      // near-zero vectors
      dx = srand(-4, 4);
      dz = srand(-4, 4);
    end else if (pick < 84) begin
      // on an axis
      dx = srand(-2000, 2000);
      dz = srand(-2000, 2000);
      if ($urandom_range(1)) dx = 0;
      else dz = 0;
    end else if (pick < 89) begin
      dx = 0;
      dz = 0;
    end else begin
      return mk_item(op, $urandom(), $urandom(), $urandom(), $urandom(),
                     ($urandom_range(1)) ? 16'hFFFF : $urandom_range(1));
    end
    return mk_item(op, ox + dx, oz + dz, ox, oz, $urandom());
  endfunction

  task automatic send_item(track_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.ts, it.oz, it.ox, it.tz, it.tx};
    s_axis_tuser  <= it.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_accepted(it);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic write_turn_rate(logic [15:0] rate);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rate;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.turn_rate = rate;
  endtask

  initial begin
    track_item_t opening[$];
    logic [15:0] rate;
    sb = new(CordicIters);
    tx_idle_pct = 26;
    rx_idle_pct = 63;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at full turn rate
    write_turn_rate(16'hFFFF);
    opening = '{
      mk_item(OP_SNAP, 0, 0, 0, 0, 0),                  // zero vector
      mk_item(OP_SNAP, 0, -100, 0, 0, 0),               // straight behind: pi
      mk_item(OP_SNAP, 5, 5, 5, 5, 65535),              // zero vector again
      mk_item(OP_TURN, 0, -1, 0, 0, 65535),             // half turn, step saturates
      mk_item(OP_TURN, 100, 0, 0, 0, 0),                // zero step
      mk_item(OP_SNAP, 0, 1, 0, 0, 0),
      mk_item(OP_TURN, 0, -1, 0, 0, 16'h0100),          // half turn, small step
      mk_item(OP_SNAP, 32767, 32767, -32768, -32768, 0),
      mk_item(OP_SNAP, -32768, 32767, 32767, -32768, 0),
      mk_item(OP_TURN, -32768, -32768, 32767, 32767, 65535),
      mk_item(OP_TURN, 32767, -32768, -32768, 32767, 1),
      mk_item(OP_TURN, 32767, -32768, -32768, 32767, 2),
      mk_item(OP_TURN, 1, 0, 0, 0, 16'h4000),
      mk_item(OP_SNAP, -1, 0, 0, 0, 0),
      mk_item(OP_TURN, 0, 32767, 0, -32768, 16'h8000),
      mk_item(OP_SNAP, 1, -1, 0, 0, 0),
      mk_item(OP_TURN, -1, 1, 0, 0, 16'hFFFF),
      mk_item(OP_SNAP, -32768, 0, 32767, 0, 0),
      mk_item(OP_TURN, 32767, 0, -32768, 0, 16'h2000),
      mk_item(OP_TURN, 3, -7, 3, -7, 16'hFFFF)
    };
    foreach (opening[i]) send_item(opening[i]);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      case (ph)
        0:       rate = 16'h0000;
        1:       rate = 16'd2500;
        2:       rate = 16'hFFFF;
        4:       rate = 16'h0001;
        default: rate = 16'($urandom_range(65535));
      endcase
      write_turn_rate(rate);
      // receiver-heavy idling, then sender-heavy, then none
      if (ph < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct = 63;
      end else if (ph < 4) begin
        tx_idle_pct = 63;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < PhaseItems; n++) send_item(next_random_item());
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (ResultLatency + 16) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("%0t timeout, %0d result items outstanding", $time, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
